// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/prk_pkg.sv =====
// ----------------------------------------------------------------------------
// Permutation rank package
// Widths, register map, control bundles and the factorial table.
// ----------------------------------------------------------------------------
package prk_pkg;

  localparam int MAX_LEN        = 12;
  localparam int ELEM_BITS      = 8;
  localparam int ELEM_W         = 8;
  localparam int RANK_W         = 29;
  localparam int DIGIT_W        = 4;
  localparam int LEN_W          = 4;
  localparam int IDX_W          = $clog2(MAX_LEN);
  localparam int CNT_W          = $clog2(MAX_LEN + 1);
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;
  localparam int PERM_LEN_RESET = 4;

  typedef enum logic {
    REG_PERM_LEN = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic             clear;
    logic             cmp_en;
    logic             wr_en;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] wr_idx;
  } dig_ctrl_t;

  typedef struct packed {
    logic             init;
    logic             mul_en;
    logic             add_en;
    logic [IDX_W-1:0] fact_sel;
  } mac_ctrl_t;

  function automatic logic [RANK_W-1:0] fact_at(input logic [IDX_W-1:0] n);
    logic [RANK_W-1:0] f;
    case (n)
      0:       f = RANK_W'(1);
      1:       f = RANK_W'(1);
      2:       f = RANK_W'(2);
      3:       f = RANK_W'(6);
      4:       f = RANK_W'(24);
      5:       f = RANK_W'(120);
      6:       f = RANK_W'(720);
      7:       f = RANK_W'(5040);
      8:       f = RANK_W'(40320);
      9:       f = RANK_W'(362880);
      10:      f = RANK_W'(3628800);
      11:      f = RANK_W'(39916800);
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ===== hw/rtl/prk_digits.sv =====
// ----------------------------------------------------------------------------
// Permutation rank digit store
// Element store and Lehmer digits with one shared magnitude comparator.
// ----------------------------------------------------------------------------
module prk_digits import prk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dig_ctrl_t            ctrl_i,
  input  logic [ELEM_BITS-1:0] elem_i,
  output logic [DIGIT_W-1:0]   digit_o
);

  logic [ELEM_BITS-1:0] elem_mem_q [MAX_LEN];
  logic [DIGIT_W-1:0]   inv_q      [MAX_LEN];
  logic                 gt;

  assign gt      = elem_mem_q[ctrl_i.idx] > elem_i;
  assign digit_o = inv_q[ctrl_i.idx];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      elem_mem_q[ctrl_i.wr_idx] <= elem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEN; i++) begin
        inv_q[i] <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < MAX_LEN; i++) begin
        inv_q[i] <= '0;
      end
    end else if (ctrl_i.cmp_en && gt) begin
      inv_q[ctrl_i.idx] <= inv_q[ctrl_i.idx] + DIGIT_W'(1);
    end
  end

endmodule

// ===== hw/rtl/prk_mac.sv =====
// ----------------------------------------------------------------------------
// Permutation rank multiply-accumulate
// Shared digit-times-factorial multiplier with a registered accumulator.
// ----------------------------------------------------------------------------
module prk_mac import prk_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mac_ctrl_t           ctrl_i,
  input  logic [DIGIT_W-1:0]  digit_i,
  output logic [RANK_W-1:0]   acc_o
);

  logic [RANK_W-1:0] prod_q;
  logic [RANK_W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= RANK_W'(digit_i * fact_at(ctrl_i.fact_sel));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.init) begin
      acc_q <= RANK_W'(1);
    end else if (ctrl_i.add_en) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== hw/rtl/permutation_rank_top.sv =====
// ----------------------------------------------------------------------------
// Permutation rank top level
// Element at position p (from 0) keeps busy high through p compare steps on
// the shared comparator, then one store step. The last element adds
// 2*len multiply/add steps and one output step; rank_valid_o pulses in the
// cycle after. Reset sets perm_length to 4 and clears digits and count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module permutation_rank_top import prk_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [ELEM_W-1:0]     elem_value_i,
  output logic [RANK_W-1:0]     rank_o,
  output logic                  rank_valid_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_STORE,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } state_e;

  state_e               state_q;
  logic [LEN_W-1:0]     perm_len_q;
  logic [CNT_W-1:0]     items_q;
  logic [IDX_W-1:0]     idx_q;
  logic [ELEM_BITS-1:0] elem_q;
  logic [RANK_W-1:0]    rank_q;
  logic                 rank_valid_q;

  logic [CNT_W-1:0]     len_eff;
  logic                 cfg_wr;
  logic                 accept;
  logic                 last_item;
  logic                 last_digit;
  dig_ctrl_t            dig_ctrl;
  mac_ctrl_t            mac_ctrl;
  logic [DIGIT_W-1:0]   digit;
  logic [RANK_W-1:0]    acc;

  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_ADDR_W-1] == REG_PERM_LEN);
  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[APB_ADDR_W-1] == REG_PERM_LEN) ?
                  APB_DATA_W'(perm_len_q) : '0;

  always_comb begin
    if (perm_len_q == '0) begin
      len_eff = CNT_W'(1);
    end else if (CNT_W'(perm_len_q) > CNT_W'(MAX_LEN)) begin
      len_eff = CNT_W'(MAX_LEN);
    end else begin
      len_eff = CNT_W'(perm_len_q);
    end
  end

  assign last_item  = (items_q + CNT_W'(1)) == len_eff;
  assign last_digit = (CNT_W'(idx_q) + CNT_W'(1)) == len_eff;

  always_comb begin
    dig_ctrl          = '0;
    dig_ctrl.idx      = idx_q;
    dig_ctrl.wr_idx   = items_q[IDX_W-1:0];
    dig_ctrl.clear    = cfg_wr || (state_q == ST_EMIT);
    dig_ctrl.cmp_en   = (state_q == ST_CMP);
    dig_ctrl.wr_en    = (state_q == ST_STORE);
    mac_ctrl          = '0;
    mac_ctrl.fact_sel = IDX_W'(len_eff - CNT_W'(1) - CNT_W'(idx_q));
    mac_ctrl.init     = (state_q == ST_STORE) && last_item;
    mac_ctrl.mul_en   = (state_q == ST_MUL);
    mac_ctrl.add_en   = (state_q == ST_ADD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      perm_len_q   <= LEN_W'(PERM_LEN_RESET);
      items_q      <= '0;
      idx_q        <= '0;
      elem_q       <= '0;
      rank_q       <= '0;
      rank_valid_q <= 1'b0;
    end else begin
      rank_valid_q <= (state_q == ST_EMIT);
      if (cfg_wr) begin
        perm_len_q <= pwdata[LEN_W-1:0];
        items_q    <= '0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            elem_q  <= elem_value_i[ELEM_BITS-1:0];
            idx_q   <= '0;
            state_q <= (items_q == '0) ? ST_STORE : ST_CMP;
          end
        end
        ST_CMP: begin
          idx_q <= idx_q + IDX_W'(1);
          if ((CNT_W'(idx_q) + CNT_W'(1)) == items_q) begin
            state_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          items_q <= items_q + CNT_W'(1);
          idx_q   <= '0;
          state_q <= last_item ? ST_MUL : ST_IDLE;
        end
        ST_MUL: begin
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          if (last_digit) begin
            state_q <= ST_EMIT;
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= ST_MUL;
          end
        end
        ST_EMIT: begin
          rank_q  <= acc;
          items_q <= '0;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rank_o       = rank_q;
  assign rank_valid_o = rank_valid_q;

  prk_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (dig_ctrl),
    .elem_i  (elem_q),
    .digit_o (digit)
  );

  prk_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .digit_i (digit),
    .acc_o   (acc)
  );

  `ASSERT_PROP(a_accept_busy, clk_i, rst_ni, accept |=> busy)
  `ASSERT_PROP(a_valid_after_emit, clk_i, rst_ni, rank_valid_o |-> $past(state_q == ST_EMIT))
  `ASSERT_NEVER(a_rank_nonzero, clk_i, rst_ni, rank_valid_o && (rank_o == '0))
  `ASSERT_PROP(a_idle_count, clk_i, rst_ni, (state_q == ST_IDLE) |-> (items_q < len_eff))

endmodule
